[rtl/core/lrupr_pkg.sv]
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared widths, defaults and the control/status bundles of the LRU page
// replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    // Port field widths
    localparam int PAGE_NUMBER_W   = 16;
    localparam int FRAME_INDEX_W   = 4;
    localparam int FRAMES_IN_USE_W = 5;

    // Parameter defaults
    localparam int FRAME_COUNT_DEF = 16;
    localparam int PAGE_BITS_DEF   = 16;

    // Reset value of the active frame count register
    localparam logic [FRAMES_IN_USE_W-1:0] FRAMES_IN_USE_RESET = 5'd16;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // latch request, clear scan trackers
        logic rd;       // read next frame of the scan
        logic commit;   // update frame state, write result
    } lrupr_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_last;    // current read is the last active frame
        logic rsp_free;     // result register can take a new result
    } lrupr_status_t;

endpackage

[rtl/core/lrupr_intf.sv]
// ----------------------------------------------------------------------------
// lrupr_intf
// Valid/ready channels of the LRU page replacement block: request,
// response and configuration write.
// ----------------------------------------------------------------------------
interface lrupr_req_if;
    logic                               valid;
    logic                               ready;
    logic [lrupr_pkg::PAGE_NUMBER_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface lrupr_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               hit;
    logic [lrupr_pkg::FRAME_INDEX_W-1:0] frame_index;
    logic                               evicted_valid;
    logic [lrupr_pkg::PAGE_NUMBER_W-1:0] evicted_page;

    modport source (output valid, output hit, output frame_index,
                    output evicted_valid, output evicted_page, input ready);
    modport sink   (input valid, input hit, input frame_index,
                    input evicted_valid, input evicted_page, output ready);
endinterface

interface lrupr_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [lrupr_pkg::FRAMES_IN_USE_W-1:0] frames_in_use;

    modport source (output valid, output frames_in_use, input ready);
    modport sink   (input valid, input frames_in_use, output ready);
endinterface

[rtl/core/lrupr_ctrl.sv]
// ----------------------------------------------------------------------------
// lrupr_ctrl
// Sequencer: takes a request, steps the frame scan, waits for the result
// register and commits the update.
// ----------------------------------------------------------------------------
module lrupr_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  lrupr_pkg::lrupr_status_t status,
    output lrupr_pkg::lrupr_cmd_t    cmd
);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        DRAIN,
        COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    // Commands decoded from the current state
    always_comb
    begin
        cmd.load   = (state_reg == IDLE) && req_valid && ready_reg;
        cmd.rd     = (state_reg == SCAN);
        cmd.commit = (state_reg == COMMIT) && status.rsp_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            IDLE:
            begin
                if (req_valid && ready_reg)
                begin
                    state_next = SCAN;
                end
            end
            SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = DRAIN;
                end
            end
            DRAIN:
            begin
                state_next = COMMIT;
            end
            COMMIT:
            begin
                if (status.rsp_free)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == IDLE);
        end
    end

    assign req_ready = ready_reg;

endmodule

[rtl/core/lrupr_dpath.sv]
// ----------------------------------------------------------------------------
// lrupr_dpath
// Frame store, valid bits, recency ranks, fill count, scan compare stage
// and the result register.
// ----------------------------------------------------------------------------
module lrupr_dpath
#(
    parameter int FRAME_COUNT = lrupr_pkg::FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = lrupr_pkg::PAGE_BITS_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  lrupr_pkg::lrupr_cmd_t                   cmd,
    output lrupr_pkg::lrupr_status_t                status,
    input  logic                                    cfg_valid,
    input  logic [lrupr_pkg::FRAMES_IN_USE_W-1:0]   cfg_frames_in_use,
    input  logic [lrupr_pkg::PAGE_NUMBER_W-1:0]     req_page_number,
    output logic                                    rsp_valid,
    input  logic                                    rsp_ready,
    output logic                                    rsp_hit,
    output logic [lrupr_pkg::FRAME_INDEX_W-1:0]     rsp_frame_index,
    output logic                                    rsp_evicted_valid,
    output logic [lrupr_pkg::PAGE_NUMBER_W-1:0]     rsp_evicted_page
);

    localparam int IDX_W  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int CNT_W  = $clog2(FRAME_COUNT + 1);
    localparam int CMP_W  = (CNT_W > lrupr_pkg::FRAMES_IN_USE_W) ?
                            CNT_W : lrupr_pkg::FRAMES_IN_USE_W;
    localparam int PN_W   = lrupr_pkg::PAGE_NUMBER_W;
    localparam int FI_W   = lrupr_pkg::FRAME_INDEX_W;

    // Configuration and frame state
    logic [lrupr_pkg::FRAMES_IN_USE_W-1:0] frames_in_use_reg;
    logic [FRAME_COUNT-1:0]                frame_valid_reg;
    logic [FRAME_COUNT-1:0]                frame_valid_next;
    logic [IDX_W-1:0]                      rank_reg  [FRAME_COUNT];
    logic [IDX_W-1:0]                      rank_next [FRAME_COUNT];
    logic [CNT_W-1:0]                      fill_count_reg;
    logic [CNT_W-1:0]                      fill_count_next;
    logic [PAGE_BITS-1:0]                  page_mem  [FRAME_COUNT];

    // Request and scan
    logic [PAGE_BITS-1:0]                  page_reg;
    logic [IDX_W-1:0]                      scan_idx_reg;
    logic [IDX_W-1:0]                      rd_idx_reg;
    logic [PAGE_BITS-1:0]                  rd_data_reg;
    logic                                  rd_pending_reg;

    // Scan trackers
    logic                                  hit_found_reg;
    logic [IDX_W-1:0]                      hit_idx_reg;
    logic [IDX_W-1:0]                      hit_rank_reg;
    logic                                  vic_found_reg;
    logic [IDX_W-1:0]                      vic_idx_reg;
    logic [IDX_W-1:0]                      vic_rank_reg;
    logic [PAGE_BITS-1:0]                  vic_page_reg;

    // Result register
    logic                                  rsp_valid_reg;
    logic                                  rsp_hit_reg;
    logic [FI_W-1:0]                       rsp_frame_index_reg;
    logic                                  rsp_evicted_valid_reg;
    logic [PN_W-1:0]                       rsp_evicted_page_reg;

    logic [PAGE_BITS+PN_W-1:0]             page_wide;
    logic [PAGE_BITS-1:0]                  page_in;
    logic [CMP_W-1:0]                      fiu_wide;
    logic [CNT_W-1:0]                      n_eff;
    logic                                  cmp_valid;
    logic [IDX_W-1:0]                      cmp_rank;
    logic                                  cmp_match;
    logic                                  cmp_older;
    logic                                  fill_room;
    logic                                  do_fill;
    logic                                  do_evict;
    logic [IDX_W-1:0]                      tgt_idx;
    logic [IDX_W-1:0]                      old_rank;
    logic [PAGE_BITS+PN_W-1:0]             ev_wide;
    logic [IDX_W+FI_W-1:0]                 idx_wide;

    // Input page reduced to PAGE_BITS
    assign page_wide = {{PAGE_BITS{1'b0}}, req_page_number};
    assign page_in   = page_wide[PAGE_BITS-1:0];

    // Effective frame count, clamped to 1 .. FRAME_COUNT
    assign fiu_wide = CMP_W'(frames_in_use_reg);
    always_comb
    begin
        if (fiu_wide == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (fiu_wide > CMP_W'(FRAME_COUNT))
        begin
            n_eff = CNT_W'(FRAME_COUNT);
        end
        else
        begin
            n_eff = CNT_W'(fiu_wide);
        end
    end

    // Status to the controller
    assign status.scan_last = (CNT_W'(scan_idx_reg) == n_eff - CNT_W'(1));
    assign status.rsp_free  = !rsp_valid_reg || rsp_ready;

    // Compare stage for the frame read last cycle
    assign cmp_valid = frame_valid_reg[rd_idx_reg];
    assign cmp_rank  = rank_reg[rd_idx_reg];
    assign cmp_match = rd_pending_reg && cmp_valid && (rd_data_reg == page_reg);
    assign cmp_older = rd_pending_reg && cmp_valid &&
                       (!vic_found_reg || (cmp_rank > vic_rank_reg));

    // Replacement decision
    assign fill_room = (fill_count_reg < n_eff);
    assign do_fill   = !hit_found_reg && fill_room;
    assign do_evict  = !hit_found_reg && !fill_room;

    always_comb
    begin
        if (hit_found_reg)
        begin
            tgt_idx = hit_idx_reg;
        end
        else if (fill_room)
        begin
            tgt_idx = fill_count_reg[IDX_W-1:0];
        end
        else
        begin
            tgt_idx = vic_idx_reg;
        end
    end

    assign old_rank = hit_found_reg ? hit_rank_reg : vic_rank_reg;

    // Rank, valid and fill count update on commit
    always_comb
    begin
        frame_valid_next = frame_valid_reg;
        fill_count_next  = fill_count_reg;
        for (int i = 0; i < FRAME_COUNT; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (cmd.commit)
        begin
            for (int i = 0; i < FRAME_COUNT; i++)
            begin
                if ((IDX_W'(i) != tgt_idx) && frame_valid_reg[i] &&
                    (do_fill || (rank_reg[i] < old_rank)))
                begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
            rank_next[tgt_idx]        = '0;
            frame_valid_next[tgt_idx] = 1'b1;
            if (do_fill)
            begin
                fill_count_next = fill_count_reg + CNT_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= lrupr_pkg::FRAMES_IN_USE_RESET;
            frame_valid_reg   <= '0;
            fill_count_reg    <= '0;
            for (int i = 0; i < FRAME_COUNT; i++)
            begin
                rank_reg[i] <= '0;
            end
            rd_pending_reg    <= 1'b0;
            hit_found_reg     <= 1'b0;
            vic_found_reg     <= 1'b0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                frames_in_use_reg <= cfg_frames_in_use;
            end
            frame_valid_reg <= frame_valid_next;
            fill_count_reg  <= fill_count_next;
            for (int i = 0; i < FRAME_COUNT; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
            rd_pending_reg <= cmd.rd;
            if (cmd.load)
            begin
                hit_found_reg <= 1'b0;
                vic_found_reg <= 1'b0;
            end
            else
            begin
                if (cmp_match)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (cmp_older)
                begin
                    vic_found_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Frame page memory: scan read, commit write
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_data_reg <= page_mem[scan_idx_reg];
        end
        if (cmd.commit && !hit_found_reg)
        begin
            page_mem[tgt_idx] <= page_reg;
        end
    end

    assign ev_wide  = {{PN_W{1'b0}}, vic_page_reg};
    assign idx_wide = {{FI_W{1'b0}}, tgt_idx};

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg     <= page_in;
            scan_idx_reg <= '0;
        end
        else if (cmd.rd)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end
        if (cmd.rd)
        begin
            rd_idx_reg <= scan_idx_reg;
        end
        if (!cmd.load && cmp_match && !hit_found_reg)
        begin
            hit_idx_reg  <= rd_idx_reg;
            hit_rank_reg <= cmp_rank;
        end
        if (!cmd.load && cmp_older)
        begin
            vic_idx_reg  <= rd_idx_reg;
            vic_rank_reg <= cmp_rank;
            vic_page_reg <= rd_data_reg;
        end
        if (cmd.commit)
        begin
            rsp_hit_reg           <= hit_found_reg;
            rsp_frame_index_reg   <= idx_wide[FI_W-1:0];
            rsp_evicted_valid_reg <= do_evict;
            rsp_evicted_page_reg  <= do_evict ? ev_wide[PN_W-1:0] : '0;
        end
    end

    assign rsp_valid         = rsp_valid_reg;
    assign rsp_hit           = rsp_hit_reg;
    assign rsp_frame_index   = rsp_frame_index_reg;
    assign rsp_evicted_valid = rsp_evicted_valid_reg;
    assign rsp_evicted_page  = rsp_evicted_page_reg;

    // Checks
    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!rsp_valid_reg || rsp_ready))
        else $error("commit with result register still occupied");

    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rd && cmd.commit))
        else $error("page memory read and write in the same cycle");

    a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(frame_valid_reg) == int'(fill_count_reg))
        else $error("valid frame count differs from fill count");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(FRAME_COUNT))
        else $error("fill count beyond frame count");

    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (rsp_valid_reg && frame_valid_reg[$past(tgt_idx)]))
        else $error("commit did not post a result or mark the frame valid");

endmodule

[rtl/core/lru_page_replacement.sv]
// ----------------------------------------------------------------------------
// lru_page_replacement
// The scan covers n frames, n being the effective frame count
// (frames_in_use clamped to 1 .. FRAME_COUNT); a new request is taken only
// after the previous one is committed. The scan reads one frame a cycle through
// the single port of the page memory. Results wait in an output
// register. Reset: no frames valid, ranks and fill count zero,
// frames_in_use = 16; no clearing pass, a request is taken right after reset.
// ----------------------------------------------------------------------------
module lru_page_replacement
#(
    parameter int FRAME_COUNT = lrupr_pkg::FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = lrupr_pkg::PAGE_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    lrupr_cfg_if.sink    cfg,
    lrupr_req_if.sink    req,
    lrupr_rsp_if.source  rsp
);

    lrupr_pkg::lrupr_cmd_t    cmd;
    lrupr_pkg::lrupr_status_t status;

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    // Sequencer
    lrupr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Frame state and result path
    lrupr_dpath
    #(
        .FRAME_COUNT (FRAME_COUNT),
        .PAGE_BITS   (PAGE_BITS)
    )
    u_dpath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_valid         (cfg.valid),
        .cfg_frames_in_use (cfg.frames_in_use),
        .req_page_number   (req.page_number),
        .rsp_valid         (rsp.valid),
        .rsp_ready         (rsp.ready),
        .rsp_hit           (rsp.hit),
        .rsp_frame_index   (rsp.frame_index),
        .rsp_evicted_valid (rsp.evicted_valid),
        .rsp_evicted_page  (rsp.evicted_page)
    );

endmodule
